// File: rtl/srfp_pkg.sv
package srfp_pkg;

	// Field widths
	localparam int DIST_W  = 10;
	localparam int STALE_W = 8;
	localparam int DIR_W   = 16;
	localparam int VEC_W   = 11;
	localparam int PROD_W  = DIST_W + 1 + DIR_W;
	localparam int BYTE_W  = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_TDATA_W = 48;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Input kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_STALE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_X     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Y     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Z     = 3'd5;

	// Frame characters
	localparam logic [BYTE_W-1:0] CHAR_R     = 8'h52;
	localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [STALE_W-1:0] STALE_SAT = 8'hFF;

	// Reset values of the registers
	localparam logic [DIST_W-1:0]  MIN_DIST_RST  = 10'd0;
	localparam logic [DIST_W-1:0]  MAX_DIST_RST  = 10'd999;
	localparam logic [STALE_W-1:0] MAX_STALE_RST = 8'd5;
	localparam logic signed [DIR_W-1:0] DIR_X_RST = 16'sd0;
	localparam logic signed [DIR_W-1:0] DIR_Y_RST = 16'sd0;
	localparam logic signed [DIR_W-1:0] DIR_Z_RST = -16'sd16384;

	// Q2.14 scaling
	localparam int FRAC_BITS = 14;

	typedef struct packed {
		logic [DIST_W-1:0]       min_dist;
		logic [DIST_W-1:0]       max_dist;
		logic [STALE_W-1:0]      max_stale;
		logic signed [DIR_W-1:0] dir_x;
		logic signed [DIR_W-1:0] dir_y;
		logic signed [DIR_W-1:0] dir_z;
	} cfg_t;

	// One sample job handed from front to back
	typedef struct packed {
		logic [DIST_W-1:0] dist_cm;
		logic              healthy;
	} job_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic full;
		logic not_empty;
	} q_status_t;

	// Round half away from zero by 2^FRAC_BITS, then saturate to VEC_W bits
	function automatic logic [VEC_W-1:0] round_sat(input logic signed [PROD_W-1:0] prod);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] rnd;
		logic [VEC_W-1:0]  res;
		mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
		rnd = (mag + PROD_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		if (prod[PROD_W-1]) begin
			if (rnd >= PROD_W'(1 << (VEC_W - 1)))
				res = {1'b1, {(VEC_W-1){1'b0}}};
			else
				res = VEC_W'(-rnd);
		end else begin
			if (rnd >= PROD_W'(1 << (VEC_W - 1)))
				res = {1'b0, {(VEC_W-1){1'b1}}};
			else
				res = rnd[VEC_W-1:0];
		end
		return res;
	endfunction

endpackage

// File: rtl/srfp_front.sv
module srfp_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_accept,
	input  logic                            in_kind,
	input  logic [srfp_pkg::BYTE_W-1:0]     in_byte,
	input  srfp_pkg::cfg_t                  cfg,
	output logic                            push,
	output srfp_pkg::job_t                  push_job
);

	localparam logic [2:0] PH_HUNT  = 3'd0;
	localparam logic [2:0] PH_CHAR1 = 3'd1;
	localparam logic [2:0] PH_CHAR2 = 3'd2;
	localparam logic [2:0] PH_CHAR3 = 3'd3;
	localparam logic [2:0] PH_TERM  = 3'd4;

	logic [2:0]                     phase_q;
	logic [srfp_pkg::DIST_W-1:0]    digit_q;
	logic                           stopped_q;
	logic [srfp_pkg::DIST_W-1:0]    last_dist_q;
	logic [srfp_pkg::STALE_W-1:0]   ticks_q;

	logic                           is_digit;
	logic [srfp_pkg::DIST_W-1:0]    digit_next;
	logic [srfp_pkg::DIST_W-1:0]    floor_d;
	logic                           byte_acc;
	logic                           tick_acc;

	assign byte_acc = in_accept && (in_kind == srfp_pkg::KIND_BYTE);
	assign tick_acc = in_accept && (in_kind == srfp_pkg::KIND_TICK);

	// Decimal accumulate, wraps at 10 bits
	assign is_digit = (in_byte >= srfp_pkg::CHAR_ZERO) && (in_byte <= srfp_pkg::CHAR_NINE);
	assign digit_next = (digit_q << 3) + (digit_q << 1)
		+ srfp_pkg::DIST_W'(in_byte - srfp_pkg::CHAR_ZERO);

	// Frame parser
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			digit_q     <= '0;
			stopped_q   <= 1'b0;
			last_dist_q <= '0;
		end else if (byte_acc) begin
			unique case (phase_q)
				PH_CHAR1, PH_CHAR2, PH_CHAR3: begin
					if (!stopped_q && is_digit)
						digit_q <= digit_next;
					else
						stopped_q <= 1'b1;
					phase_q <= phase_q + 3'd1;
				end
				PH_TERM: begin
					last_dist_q <= digit_q;
					phase_q     <= PH_HUNT;
				end
				default: begin
					if (in_byte == srfp_pkg::CHAR_R) begin
						digit_q   <= '0;
						stopped_q <= 1'b0;
						phase_q   <= PH_CHAR1;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
			endcase
		end
	end

	// Staleness counter: cleared on commit, saturating count of ticks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= srfp_pkg::STALE_SAT;
		end else if (byte_acc && phase_q == PH_TERM) begin
			ticks_q <= '0;
		end else if (tick_acc && ticks_q != srfp_pkg::STALE_SAT) begin
			ticks_q <= ticks_q + 1'b1;
		end
	end

	// Clamp floor first, then ceiling
	assign floor_d = (last_dist_q < cfg.min_dist) ? cfg.min_dist : last_dist_q;

	assign push = tick_acc;
	assign push_job.dist_cm = (floor_d > cfg.max_dist) ? cfg.max_dist : floor_d;
	assign push_job.healthy = (last_dist_q >= cfg.min_dist) && (last_dist_q <= cfg.max_dist)
		&& (ticks_q <= cfg.max_stale);

endmodule

// File: rtl/srfp_queue.sv
module srfp_queue #(
	parameter int DEPTH = srfp_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  srfp_pkg::job_t     push_job,
	input  logic               pop,
	output srfp_pkg::job_t     pop_job,
	output srfp_pkg::q_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	srfp_pkg::job_t     mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	assign pop_job          = mem_q[rd_ptr_q];
	assign status.full      = (count_q == FULL_CNT);
	assign status.not_empty = (count_q != '0);

endmodule

// File: rtl/srfp_back.sv
module srfp_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            job_valid,
	input  srfp_pkg::job_t                  job,
	output logic                            pop,
	input  srfp_pkg::cfg_t                  cfg,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [srfp_pkg::DIST_W-1:0]     out_dist,
	output logic                            out_healthy,
	output logic [srfp_pkg::VEC_W-1:0]      out_x,
	output logic [srfp_pkg::VEC_W-1:0]      out_y,
	output logic [srfp_pkg::VEC_W-1:0]      out_z
);

	logic                                   vld_s1;
	srfp_pkg::job_t                         job_s1;
	logic signed [srfp_pkg::PROD_W-1:0]     prod_x_s1;
	logic signed [srfp_pkg::PROD_W-1:0]     prod_y_s1;
	logic signed [srfp_pkg::PROD_W-1:0]     prod_z_s1;

	logic                                   vld_s2;
	logic                                   adv_s2;
	logic                                   adv_s1;
	logic signed [srfp_pkg::DIST_W:0]       dist_sx;

	// Stage advance: output register frees when taken
	assign adv_s2 = !vld_s2 || out_ready;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign pop    = job_valid && adv_s1;

	assign dist_sx = $signed({1'b0, job.dist_cm});

	// Stage 1: products of distance and direction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (adv_s1)
			vld_s1 <= job_valid;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_s1    <= job;
			prod_x_s1 <= dist_sx * cfg.dir_x;
			prod_y_s1 <= dist_sx * cfg.dir_y;
			prod_z_s1 <= dist_sx * cfg.dir_z;
		end
	end

	// Stage 2: rounding, saturation, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (adv_s2)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			out_dist    <= job_s1.dist_cm;
			out_healthy <= job_s1.healthy;
			out_x       <= srfp_pkg::round_sat(prod_x_s1);
			out_y       <= srfp_pkg::round_sat(prod_y_s1);
			out_z       <= srfp_pkg::round_sat(prod_z_s1);
		end
	end

	assign out_valid = vld_s2;

endmodule

// File: rtl/sonar_range_frame_parser_unit.sv
// Sonar range frame parser.
// Slave stream: one item per transfer; s_tuser is the kind (0 = serial byte,
// 1 = sample tick), s_tdata the received byte. Bytes are parsed as frames
// 'R' c c c t; the terminator commits the distance read from the leading
// decimal digits. Each tick produces one master transfer carrying the
// clamped distance, the health flag and the distance scaled by the
// Q2.14 direction; bytes produce no output.
// Config channel: cfg_index selects a register (0 min, 1 max, 2 stale limit,
// 3..5 direction x/y/z), cfg_data the value; always ready. Write only when
// no tick is in flight.
// Throughput: one item per cycle while s_tready is high. A tick accepted
// passes the job queue and the multiply stage, then is rounded/saturated
// into the output register, which drives m_tvalid.
// When the receiver stalls, results wait in the output register, the
// multiply stage and a small job queue; s_tready drops only once that queue
// is full. Reset clears the parser, the staleness count (to saturated) and
// all registers to their defaults; no clearing pass is needed.
module sonar_range_frame_parser_unit #(
	parameter int QUEUE_DEPTH = srfp_pkg::QUEUE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [srfp_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] rx_byte
	input  logic                                s_tuser,   // [0] kind
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [srfp_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [9:0] distance_cm, [20:10] vec_x,
	                                                       // [31:21] vec_y, [42:32] vec_z, rest 0
	output logic                                m_tuser,   // [0] healthy
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [srfp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [srfp_pkg::CFG_DATA_W-1:0]     cfg_data
);

	srfp_pkg::cfg_t             cfg_q;
	srfp_pkg::job_t             push_job;
	srfp_pkg::job_t             pop_job;
	srfp_pkg::q_status_t        q_status;
	logic                       push;
	logic                       pop;
	logic                       in_accept;
	logic [srfp_pkg::DIST_W-1:0] out_dist;
	logic                       out_healthy;
	logic [srfp_pkg::VEC_W-1:0] out_x;
	logic [srfp_pkg::VEC_W-1:0] out_y;
	logic [srfp_pkg::VEC_W-1:0] out_z;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_dist  <= srfp_pkg::MIN_DIST_RST;
			cfg_q.max_dist  <= srfp_pkg::MAX_DIST_RST;
			cfg_q.max_stale <= srfp_pkg::MAX_STALE_RST;
			cfg_q.dir_x     <= srfp_pkg::DIR_X_RST;
			cfg_q.dir_y     <= srfp_pkg::DIR_Y_RST;
			cfg_q.dir_z     <= srfp_pkg::DIR_Z_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				srfp_pkg::REG_MIN_DIST:  cfg_q.min_dist  <= cfg_data[srfp_pkg::DIST_W-1:0];
				srfp_pkg::REG_MAX_DIST:  cfg_q.max_dist  <= cfg_data[srfp_pkg::DIST_W-1:0];
				srfp_pkg::REG_MAX_STALE: cfg_q.max_stale <= cfg_data[srfp_pkg::STALE_W-1:0];
				srfp_pkg::REG_DIR_X:     cfg_q.dir_x     <= $signed(cfg_data);
				srfp_pkg::REG_DIR_Y:     cfg_q.dir_y     <= $signed(cfg_data);
				srfp_pkg::REG_DIR_Z:     cfg_q.dir_z     <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// Input handshake: held off only by a full job queue
	assign s_tready  = !q_status.full;
	assign in_accept = s_tvalid && s_tready;

	srfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.in_kind   (s_tuser),
		.in_byte   (s_tdata),
		.cfg       (cfg_q),
		.push      (push),
		.push_job  (push_job)
	);

	srfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.status   (q_status)
	);

	srfp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (q_status.not_empty),
		.job         (pop_job),
		.pop         (pop),
		.cfg         (cfg_q),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_dist    (out_dist),
		.out_healthy (out_healthy),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_z       (out_z)
	);

	// Output packing
	assign m_tdata = {
		{(srfp_pkg::OUT_TDATA_W - srfp_pkg::DIST_W - 3 * srfp_pkg::VEC_W){1'b0}},
		out_z, out_y, out_x, out_dist
	};
	assign m_tuser = out_healthy;

	// Queue is never popped empty
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_status.not_empty)
		else $error("job queue popped while empty");

	// Queue is never pushed full
	a_push_notfull: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("job queue pushed while full");

	// A healthy sample lies within the configured range
	a_healthy_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (out_dist >= cfg_q.min_dist && out_dist <= cfg_q.max_dist))
		else $error("healthy sample outside configured range");

	// A tick accepted into an empty back end is presented on m_tvalid
	a_tick_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_status.not_empty && !m_tvalid) |-> ##3 m_tvalid)
		else $error("tick result not presented on time");

endmodule
